### rtl/fbrgba_pkg.sv
// ----------------------------------------------------------------------------
// fbrgba_pkg
// Shared types, register indexes, reset values and the short-field rescale
// table for the framebuffer pixel to RGBA8888 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fbrgba_pkg;

  // Register file geometry
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int BPP_W = 6;
  localparam int LAYOUT_W = 11;
  localparam int LEN_W = 6;
  localparam int OFF_W = 5;
  localparam int PIX_W = 32;
  localparam int CH_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BPP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd4;

  // Supported pixel sizes
  localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  // Reset values: 32 bpp, A8 R8 G8 B8 from the top byte down
  localparam logic [BPP_W-1:0] BPP_RST = 6'd32;
  localparam logic [LAYOUT_W-1:0] RED_RST = 11'd1032;
  localparam logic [LAYOUT_W-1:0] GREEN_RST = 11'd520;
  localparam logic [LAYOUT_W-1:0] BLUE_RST = 11'd8;
  localparam logic [LAYOUT_W-1:0] ALPHA_RST = 11'd1544;

  // Field length limits
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;
  localparam logic [LEN_W-1:0] LEN_BYTE = 6'd8;

  localparam int LUT_DEPTH = 256;
  typedef logic [CH_W-1:0] lut_t [LUT_DEPTH];

  // Length of a layout word, saturated at the pixel word size
  function automatic logic [LEN_W-1:0] field_len(input logic [LAYOUT_W-1:0] layout);
    logic [LEN_W-1:0] len;
    len = layout[LEN_W-1:0];
    return (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // Rescale table for 1..7 bit fields: round(v*255/max), max = 2^len-1.
  // Lengths are packed back to back; length L starts at entry 2^L-2.
  // Evaluated once at elaboration.
  function automatic lut_t build_rescale_lut();
    lut_t lut;
    int len;
    int v;
    int r;
    int maxv;
    int x;
    int q;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      lut[i] = '0;
    end
    for (len = 1; len <= 7; len++) begin
      maxv = (1 << len) - 1;
      for (v = 0; v <= maxv; v++) begin
        x = v * 255 + (maxv >> 1);
        q = 0;
        for (r = 0; r < 256; r++) begin
          if (r * maxv <= x) begin
            q = r;
          end
        end
        lut[(1 << len) - 2 + v] = CH_W'(q);
      end
    end
    return lut;
  endfunction

  localparam lut_t RESCALE_LUT = build_rescale_lut();

endpackage

`default_nettype wire

### rtl/fbrgba_channel.sv
// ----------------------------------------------------------------------------
// fbrgba_channel
// One color channel: bit field extraction and scaling to 8 bits, two
// register stages (shift, then scale).
// ----------------------------------------------------------------------------
`default_nettype none

module fbrgba_channel
  import fbrgba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [LAYOUT_W-1:0] layout,
  input  wire logic                opaque,
  input  wire logic [PIX_W-1:0]    raw,
  input  wire logic                clear,
  output logic      [CH_W-1:0]     ch
);

  logic [LEN_W-1:0] len;
  logic [OFF_W-1:0] off;
  logic [LEN_W-1:0] shamt;
  logic [PIX_W-1:0] shifted;

  logic [CH_W-1:0]  field;
  logic [LEN_W-1:0] field_len_q;

  logic [2:0]       short_len;
  logic [CH_W-1:0]  short_mask;
  logic [CH_W-1:0]  lut_idx;
  logic [CH_W-1:0]  ch_next;

  // Stage A: align the field so its top byte (or the whole short field)
  // sits at bit 0; shifts past the pixel give zero
  always_comb begin
    len = field_len(layout);
    off = layout[LAYOUT_W-1:LEN_W];
    if (len >= LEN_BYTE) begin
      shamt = LEN_W'(off) + (len - LEN_BYTE);
    end else begin
      shamt = LEN_W'(off);
    end
    shifted = raw >> shamt;
  end

  always_ff @(posedge clk) begin
    field <= shifted[CH_W-1:0];
    field_len_q <= len;
  end

  // Stage B: clear, keep the byte, rescale a short field or fill a zero length
  always_comb begin
    short_len = field_len_q[2:0];
    short_mask = (CH_W'(1) << short_len) - CH_W'(1);
    lut_idx = (CH_W'(1) << short_len) - CH_W'(2) + (field & short_mask);
    if (clear) begin
      ch_next = '0;
    end else if (field_len_q == '0) begin
      ch_next = opaque ? '1 : '0;
    end else if (field_len_q >= LEN_BYTE) begin
      ch_next = field;
    end else begin
      ch_next = RESCALE_LUT[lut_idx];
    end
  end

  always_ff @(posedge clk) begin
    ch <= ch_next;
  end

endmodule

`default_nettype wire

### rtl/framebuffer_pixel_to_rgba8888.sv
// ----------------------------------------------------------------------------
// framebuffer_pixel_to_rgba8888
// Converts one framebuffer pixel (16, 24 or 32 bpp, configurable bit fields)
// to 8-bit red, green, blue and alpha per clock.
//
//   Channel   Signals                                   Direction  Handshake
//   request   start, busy, pixel_bytes                  in         start & !busy
//   result    done, red_out, green_out, blue_out,       out        done strobe
//             alpha_out, format_error
//   config    cfg_we, cfg_index, cfg_data               in         cfg_we
//
// One request per clock; busy is never raised. The pipeline registers are
// input capture and size masking, field shift, then scale/table lookup.
// Results appear for one cycle under done and cannot be held off.
// Synchronous reset clears the pipeline valids and restores the default
// register values (32 bpp, A8 R8 G8 B8).
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_pixel_to_rgba8888
  import fbrgba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PIX_W-1:0]      pixel_bytes,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       done,
  output logic [CH_W-1:0]            red_out,
  output logic [CH_W-1:0]            green_out,
  output logic [CH_W-1:0]            blue_out,
  output logic [CH_W-1:0]            alpha_out,
  output logic                       format_error
);

  logic [BPP_W-1:0]    pixel_size;
  logic [LAYOUT_W-1:0] red_layout;
  logic [LAYOUT_W-1:0] green_layout;
  logic [LAYOUT_W-1:0] blue_layout;
  logic [LAYOUT_W-1:0] alpha_layout;

  logic             accept;
  logic [PIX_W-1:0] raw_next;
  logic             err_next;

  logic             vld_s1;
  logic             vld_s2;
  logic             err_s1;
  logic             err_s2;
  logic [PIX_W-1:0] raw_s1;

  assign busy = 1'b0;
  assign accept = start & ~busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_size <= BPP_RST;
      red_layout <= RED_RST;
      green_layout <= GREEN_RST;
      blue_layout <= BLUE_RST;
      alpha_layout <= ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BPP:   pixel_size <= cfg_data[BPP_W-1:0];
        REG_RED:   red_layout <= cfg_data[LAYOUT_W-1:0];
        REG_GREEN: green_layout <= cfg_data[LAYOUT_W-1:0];
        REG_BLUE:  blue_layout <= cfg_data[LAYOUT_W-1:0];
        REG_ALPHA: alpha_layout <= cfg_data[LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel size: keep the low 2, 3 or 4 bytes, flag anything else
  always_comb begin
    raw_next = '0;
    err_next = 1'b0;
    case (pixel_size)
      BPP_16:  raw_next = {16'd0, pixel_bytes[15:0]};
      BPP_24:  raw_next = {8'd0, pixel_bytes[23:0]};
      BPP_32:  raw_next = pixel_bytes;
      default: err_next = 1'b1;
    endcase
  end

  // Stage 1 payload and the error flag through the later stages
  always_ff @(posedge clk) begin
    raw_s1 <= raw_next;
    err_s1 <= err_next;
    err_s2 <= err_s1;
    format_error <= err_s2;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1 <= 1'b0;
      vld_s2 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld_s1 <= accept;
      vld_s2 <= vld_s1;
      done <= vld_s2;
    end
  end

  // Channel extractors (stages 2 and 3)
  fbrgba_channel u_red (
    .clk    (clk),
    .layout (red_layout),
    .opaque (1'b0),
    .raw    (raw_s1),
    .clear  (err_s2),
    .ch     (red_out)
  );

  fbrgba_channel u_green (
    .clk    (clk),
    .layout (green_layout),
    .opaque (1'b0),
    .raw    (raw_s1),
    .clear  (err_s2),
    .ch     (green_out)
  );

  fbrgba_channel u_blue (
    .clk    (clk),
    .layout (blue_layout),
    .opaque (1'b0),
    .raw    (raw_s1),
    .clear  (err_s2),
    .ch     (blue_out)
  );

  fbrgba_channel u_alpha (
    .clk    (clk),
    .layout (alpha_layout),
    .opaque (1'b1),
    .raw    (raw_s1),
    .clear  (err_s2),
    .ch     (alpha_out)
  );

endmodule

`default_nettype wire

### verif/tb_framebuffer_pixel_to_rgba8888.sv
// ----------------------------------------------------------------------------
// tb_framebuffer_pixel_to_rgba8888
// Self-checking bench for the pixel to RGBA8888 converter. A queue of pixels
// feeds a request driver with random idle bursts. A monitor predicts each
// result from a local copy of the format registers and compares every channel
// and the error flag in order. Registers are rewritten between batches once
// the block has drained: fixed corner formats first, then random ones.
// ----------------------------------------------------------------------------
module tb_framebuffer_pixel_to_rgba8888;
  timeunit 1ns;
  timeprecision 1ps;

  import fbrgba_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  // Index past the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            fmt_err;
  } rgba_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      pixel_bytes = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [CH_W-1:0]       red_out;
  logic [CH_W-1:0]       green_out;
  logic [CH_W-1:0]       blue_out;
  logic [CH_W-1:0]       alpha_out;
  logic                  format_error;

  // Local copy of the format registers
  logic [BPP_W-1:0]    fmt_bpp = BPP_RST;
  logic [LAYOUT_W-1:0] fmt_red = RED_RST;
  logic [LAYOUT_W-1:0] fmt_green = GREEN_RST;
  logic [LAYOUT_W-1:0] fmt_blue = BLUE_RST;
  logic [LAYOUT_W-1:0] fmt_alpha = ALPHA_RST;

  logic [PIX_W-1:0] pixel_queue[$];
  rgba_t            rgba_expected[$];
  logic             req_taken = 1'b0;
  int               idle_pct = 0;
  int               idle_left = 0;
  int               mismatch_count = 0;
  int               pixels_sent = 0;
  int               results_checked = 0;
  int               bad_size_results = 0;
  int               reg_writes = 0;
  int               formats_used = 0;
  int               cycle_count = 0;

  framebuffer_pixel_to_rgba8888 i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_bytes  (pixel_bytes),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .alpha_out    (alpha_out),
    .format_error (format_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("tb_framebuffer_pixel_to_rgba8888: FAIL");
      $finish;
    end
  end

  // One channel: pull the field, keep its top byte or stretch a short one
  function automatic logic [CH_W-1:0] channel_value(input logic [PIX_W-1:0] word,
                                                    input logic [LAYOUT_W-1:0] layout);
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    logic [PIX_W-1:0] bits;
    int unsigned      span;
    off = layout[LAYOUT_W-1:LEN_W];
    len = (layout[LEN_W-1:0] > LEN_MAX) ? LEN_MAX : layout[LEN_W-1:0];
    bits = word >> off;
    if (len < LEN_MAX) bits = bits & ((PIX_W'(1) << len) - 1);
    if (len == 0) return '0;
    if (len >= LEN_BYTE) return CH_W'(bits >> (len - LEN_BYTE));
    span = (1 << len) - 1;
    return CH_W'((bits * 255 + span / 2) / span);
  endfunction

  function automatic rgba_t predict_rgba(input logic [PIX_W-1:0] pix);
    rgba_t            res;
    logic [PIX_W-1:0] word;
    res = '0;
    case (fmt_bpp)
      BPP_16: word = pix & 32'h0000_FFFF;
      BPP_24: word = pix & 32'h00FF_FFFF;
      BPP_32: word = pix;
      default: begin
        // unsupported size: flag only, channels stay zero
        res.fmt_err = 1'b1;
        return res;
      end
    endcase
    res.red = channel_value(word, fmt_red);
    res.green = channel_value(word, fmt_green);
    res.blue = channel_value(word, fmt_blue);
    // no alpha field means opaque
    res.alpha = (fmt_alpha[LEN_W-1:0] == 0) ? 8'hFF : channel_value(word, fmt_alpha);
    return res;
  endfunction

  task automatic check_field(input string tag, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      mismatch_count++;
    end
  endtask

  // Request driver: inputs change on the falling edge
  always @(negedge clk) begin : drive_proc
    logic             nxt_start;
    logic [PIX_W-1:0] nxt_pix;
    nxt_start = start;
    nxt_pix = pixel_bytes;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && req_taken) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pixel_queue.size() != 0) begin
          if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            idle_left = $urandom_range(5, 1) - 1;
          end else begin
            nxt_start = 1'b1;
            nxt_pix = pixel_queue.pop_front();
          end
        end
      end
    end
    start <= nxt_start;
    pixel_bytes <= nxt_pix;
  end

  // Monitor: log accepted requests, check results on the rising edge
  always @(posedge clk) begin : watch_proc
    rgba_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (start && !busy) begin
        rgba_expected.push_back(predict_rgba(pixel_bytes));
        pixels_sent++;
      end
      if (done) begin
        if (rgba_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d a=%0d err=%0b",
                   $time, red_out, green_out, blue_out, alpha_out, format_error);
          mismatch_count++;
        end else begin
          want = rgba_expected.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("alpha_out", want.alpha, alpha_out);
          check_field("format_error", CH_W'(want.fmt_err), CH_W'(format_error));
          results_checked++;
          if (want.fmt_err) bad_size_results++;
        end
      end
    end
  end

  // Register write; the local copy follows immediately since the block is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_BPP:   fmt_bpp = data[BPP_W-1:0];
      REG_RED:   fmt_red = data;
      REG_GREEN: fmt_green = data;
      REG_BLUE:  fmt_blue = data;
      REG_ALPHA: fmt_alpha = data;
      default:   ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_format(input logic [CFG_DATA_W-1:0] bpp_word,
                            input logic [LAYOUT_W-1:0] r, input logic [LAYOUT_W-1:0] g,
                            input logic [LAYOUT_W-1:0] b, input logic [LAYOUT_W-1:0] a);
    cfg_write(REG_BPP, bpp_word);
    cfg_write(REG_RED, r);
    cfg_write(REG_GREEN, g);
    cfg_write(REG_BLUE, b);
    cfg_write(REG_ALPHA, a);
    formats_used++;
  endtask

  // Hold the sender until every request has come back, then let the pipe settle
  task automatic drain();
    while (pixel_queue.size() != 0 || start || rgba_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [LAYOUT_W-1:0] random_layout();
    logic [LEN_W-1:0] len;
    case ($urandom_range(9))
      0, 1:    len = LEN_W'($urandom_range(7, 1));
      2:       len = LEN_W'($urandom_range(63, 33));
      3:       len = '0;
      default: len = LEN_W'($urandom_range(32));
    endcase
    return {OFF_W'($urandom_range(31)), len};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_bpp_word();
    logic [BPP_W-1:0] bpp;
    case ($urandom_range(7))
      0, 1:    bpp = BPP_16;
      2, 3:    bpp = BPP_24;
      4, 5:    bpp = BPP_32;
      default: bpp = BPP_W'($urandom_range(63));
    endcase
    return {(CFG_DATA_W - BPP_W)'($urandom), bpp};
  endfunction

  initial begin : stim_proc
    int random_items;
    int batch;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset format, A8 R8 G8 B8
    pixel_queue.push_back(32'h0000_0000);
    pixel_queue.push_back(32'hFFFF_FFFF);
    pixel_queue.push_back(32'h1234_5678);
    pixel_queue.push_back(32'h8080_8080);
    pixel_queue.push_back(32'h7F7F_7F7F);
    pixel_queue.push_back(32'h00FF_00FF);
    drain();

    // 16 bpp RGB565, no alpha field, upper bytes ignored
    set_format({5'h1F, BPP_16}, {5'd11, 6'd5}, {5'd5, 6'd6}, {5'd0, 6'd5}, '0);
    pixel_queue.push_back(32'hFFFF_FFFF);
    pixel_queue.push_back(32'h0000_F800);
    pixel_queue.push_back(32'h0000_07E0);
    pixel_queue.push_back(32'hABCD_001F);
    drain();

    // 24 bpp, 1/7/3 bit fields, alpha running past the pixel
    set_format({5'h0A, BPP_24}, {5'd23, 6'd1}, {5'd16, 6'd7}, {5'd0, 6'd3},
               {5'd20, 6'd8});
    pixel_queue.push_back(32'hFFFF_FFFF);
    pixel_queue.push_back(32'h0080_0000);
    pixel_queue.push_back(32'h007F_0005);
    pixel_queue.push_back(32'h00F0_0000);
    drain();

    // 32 bpp, full-word fields, saturated length, top offset, 2 bit alpha
    set_format({5'h00, BPP_32}, {5'd0, 6'd32}, 11'h7FF, {5'd31, 6'd32},
               {5'd30, 6'd2});
    pixel_queue.push_back(32'hFFFF_FFFF);
    pixel_queue.push_back(32'h8000_0000);
    pixel_queue.push_back(32'hC000_0000);
    pixel_queue.push_back(32'h40FF_FFFF);
    drain();

    // Unsupported sizes: zero and the largest value
    cfg_write(REG_BPP, {5'h1F, 6'd0});
    pixel_queue.push_back(32'hFFFF_FFFF);
    pixel_queue.push_back(32'h0000_0000);
    drain();
    cfg_write(REG_BPP, 11'h7FF);
    pixel_queue.push_back(32'h5A5A_A5A5);
    drain();

    // Unmapped index must leave the format alone
    cfg_write(REG_BPP, {5'h15, BPP_32});
    cfg_write(REG_UNMAPPED, 11'h7C0);
    pixel_queue.push_back(32'hDEAD_BEEF);
    pixel_queue.push_back(32'h0F0F_F0F0);
    drain();

    // Random formats in batches
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(REG_UNMAPPED, REG_ALPHA + 1)),
                  CFG_DATA_W'($urandom));
      set_format(random_bpp_word(), random_layout(), random_layout(), random_layout(),
                 random_layout());
      if (random_items > RANDOM_ITEMS - 250) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      batch = $urandom_range(70, 20);
      repeat (batch) begin
        case ($urandom_range(15))
          0:       pixel_queue.push_back('0);
          1:       pixel_queue.push_back('1);
          default: pixel_queue.push_back($urandom);
        endcase
      end
      random_items += batch;
      drain();
    end

    $display("Covered %0d pixels across %0d formats with %0d register writes",
             pixels_sent, formats_used, reg_writes);
    $display("Checked %0d results, %0d of them with an unsupported pixel size",
             results_checked, bad_size_results);
    if (mismatch_count == 0 && rgba_expected.size() == 0) begin
      $display("tb_framebuffer_pixel_to_rgba8888: PASS");
    end else begin
      $display("tb_framebuffer_pixel_to_rgba8888: FAIL");
    end
    $finish;
  end

endmodule
